FILE: sv/bba_pkg.sv
// shared types and constants for the buddy bitmap allocator
`timescale 1ns / 1ps
package bba_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_HEAP_BASE = 2'd0,
    REG_MIN_LOG2  = 2'd1,
    REG_ORD_CNT   = 2'd2,
    REG_UNIT_CNT  = 2'd3
  } reg_idx_e;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_SCAN,
    S_SCAN_CHK,
    S_DESC,
    S_ANC,
    S_ANC_CHK,
    S_FREE_CHK,
    S_FREE_ORD,
    S_BUDDY,
    S_BUDDY_CHK,
    S_DONE,
    S_CLEAR
  } state_e;

endpackage

FILE: sv/bba_bitmap.sv
// used-bit memory with one read port and one write port, registered read
`timescale 1ns / 1ps
module bba_bitmap #(
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic                     rdata_o
);
  logic mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/buddy_bitmap_allocator_core.sv
// buddy allocator top level: sequencer around a used-bit memory and an order table
// allocate: find the order, scan its entries, mark the descendants, then mark ancestors up to a used one;
//   free: check the address, look up the order, clear the descendants, then clear parents while the buddy is free
// all bitmap work goes through the used-bit memory, one read and one write a cycle
// one item at a time: the next beat is taken the cycle after the result beat is taken
// after reset a clearing pass zeroes every bitmap slot; input not ready meanwhile
// the result is held in an output register until taken
`timescale 1ns / 1ps
module buddy_bitmap_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned NUM_UNITS  = 1024,
  parameter int unsigned MAX_ORDERS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] free_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] block_addr_o,
  output logic [3:0]  block_order_o
);
  localparam int unsigned Slots = 2 * NUM_UNITS;
  localparam int unsigned SW    = $clog2(Slots);
  localparam int unsigned UW    = $clog2(NUM_UNITS);
  localparam int unsigned CW    = UW + 1;

  logic [31:0] heap_base_q;
  logic [4:0]  min_log2_q;
  logic [3:0]  ord_cnt_q;
  logic [10:0] unit_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      min_log2_q  <= 5'd11;
      ord_cnt_q   <= 4'd11;
      unit_cnt_q  <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HEAP_BASE: heap_base_q <= cfg_wdata_i;
        REG_MIN_LOG2:  min_log2_q  <= cfg_wdata_i[4:0];
        REG_ORD_CNT:   ord_cnt_q   <= cfg_wdata_i[3:0];
        REG_UNIT_CNT:  unit_cnt_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // effective limits
  logic [CW-1:0] units;
  logic [3:0]    d;
  always_comb begin
    if ({21'd0, unit_cnt_q} < 32'(NUM_UNITS)) units = CW'(unit_cnt_q);
    else units = CW'(NUM_UNITS);
    if (32'(ord_cnt_q) < 32'(MAX_ORDERS)) d = ord_cnt_q;
    else d = 4'(MAX_ORDERS);
  end

  state_e state_q, state_d;
  logic [31:0]   size_q;
  logic [31:0]   addr_q;
  logic [3:0]    ord_q, ord_d;
  logic [3:0]    k_q, k_d;     // level walked
  logic [CW-1:0] n_q, n_d;     // entry index at ord
  logic [CW-1:0] p_q, p_d;     // index at level k
  logic [CW-1:0] j_q, j_d;     // descendant index
  logic [CW-1:0] jend_q, jend_d;
  logic          setv_q, setv_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   baddr_q, baddr_d;
  logic [3:0]    bord_q, bord_d;
  logic          ov_q, ov_d;
  logic [SW:0]   clr_q, clr_d;

  // memory access, one bit a cycle
  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic          wdata, rdata;
  logic [3:0]    rk_q, rk_d;
  logic [CW-1:0] rn_q, rn_d;

  bba_bitmap #(.Depth(Slots)) u_bitmap (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [CW-1:0] in_heap(input logic [CW-1:0] u, input logic [3:0] k);
    return u >> k;
  endfunction

  function automatic logic [SW-1:0] slot(input logic [3:0] k, input logic [CW-1:0] n);
    logic [SW:0] b;
    b = (SW+1)'(Slots) - ((SW+1)'(Slots) >> k);
    return SW'(b + (SW+1)'(n));
  endfunction

  // beyond-heap read as used, using the address registered with the read
  logic used_rd;
  assign used_rd = (rn_q >= in_heap(units, rk_q)) ? 1'b1 : rdata;

  // order table
  logic [3:0]    uo_mem [NUM_UNITS];
  logic          uo_we;
  logic [UW-1:0] uo_waddr, uo_raddr;
  logic [3:0]    uo_rdata;
  always_ff @(posedge clk_i) begin
    if (uo_we) uo_mem[uo_waddr] <= ord_q;
    uo_rdata <= uo_mem[uo_raddr];
  end

  // free address decode
  logic [32:0] offs;
  logic [31:0] unit_full;
  assign offs      = {1'b0, addr_q} - {1'b0, heap_base_q};
  assign unit_full = offs[31:0] >> min_log2_q;
  assign uo_raddr  = unit_full[UW-1:0];

  // size compare against 2^(min_log2+k) for shared step
  logic [5:0]  sh, sh_ord;
  logic [63:0] blk_bytes, heap_bytes;
  assign sh         = {1'b0, min_log2_q} + {2'b0, k_q};
  assign sh_ord     = {1'b0, min_log2_q} + {2'b0, ord_q};
  assign blk_bytes  = 64'd1 << sh;
  assign heap_bytes = 64'(units) << min_log2_q;

  always_comb begin
    state_d = state_q;
    ord_d = ord_q; k_d = k_q; n_d = n_q; p_d = p_q; j_d = j_q; jend_d = jend_q;
    setv_d = setv_q; st_d = st_q; baddr_d = baddr_q; bord_d = bord_q;
    ov_d = ov_q; clr_d = clr_q;
    rk_d = rk_q; rn_d = rn_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (SW+1)'(Slots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          st_d = ST_BAD_SIZE; baddr_d = '0; bord_d = '0;
          k_d = '0;
          state_d = (cmd_i == CMD_FREE) ? S_FREE_CHK : S_SIZE;
        end
      end
      S_SIZE: begin
        if (size_q == 32'd0 || {32'd0, size_q} > heap_bytes || k_q >= d) begin
          state_d = S_DONE;
        end else if ({32'd0, size_q} <= blk_bytes) begin
          ord_d = k_q; n_d = '0; state_d = S_SCAN;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      S_SCAN: begin
        if (n_q >= in_heap(units, ord_q)) begin
          st_d = ST_NO_BLOCK; state_d = S_DONE;
        end else begin
          rk_d = ord_q; rn_d = n_q; state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (used_rd) begin
          n_d = n_q + 1'b1; state_d = S_SCAN;
        end else begin
          // mark entry now; walk descendants next
          setv_d = 1'b1; k_d = ord_q;
          j_d = '0; jend_d = '0;
          state_d = S_DESC;
          if (ord_q != 4'd0) begin
            k_d = ord_q - 4'd1;
            j_d = n_q << 1; jend_d = (n_q + 1'b1) << 1;
          end
        end
      end
      S_DESC: begin
        // k_q == ord_q means nothing left below
        if (k_q == ord_q || k_q == 4'hF) begin
          if (setv_q) begin
            k_d = ord_q + 4'd1; p_d = n_q; state_d = S_ANC;
          end else begin
            rk_d = ord_q; rn_d = n_q ^ CW'(1); state_d = S_BUDDY;
          end
        end else if (j_q + 1'b1 == jend_q) begin
          if (k_q == 4'd0) begin
            k_d = ord_q;
          end else begin
            k_d = k_q - 4'd1;
            j_d = n_q << (ord_q - k_q + 4'd1);
            jend_d = (n_q + 1'b1) << (ord_q - k_q + 4'd1);
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_ANC: begin
        if (k_q >= d) begin
          st_d = ST_OK;
          baddr_d = heap_base_q + 32'(64'(n_q) << sh_ord);
          bord_d = ord_q;
          state_d = S_DONE;
        end else begin
          p_d = p_q >> 1; rk_d = k_q; rn_d = p_q >> 1; state_d = S_ANC_CHK;
        end
      end
      S_ANC_CHK: begin
        // setv_q low means the clearing walk of a free
        if (setv_q) begin
          if (used_rd) begin
            k_d = d;
          end else begin
            k_d = k_q + 4'd1;
          end
          state_d = S_ANC;
        end else if (used_rd || k_q >= d) begin
          st_d = ST_OK; bord_d = ord_q; state_d = S_DONE;
        end else begin
          state_d = S_BUDDY_CHK;
        end
      end
      S_FREE_CHK: begin
        st_d = ST_BAD_ADDR;
        if (offs[32] || unit_full[31:CW] != '0 ||
            unit_full[CW-1:0] >= units) state_d = S_DONE;
        else state_d = S_FREE_ORD;
      end
      S_FREE_ORD: begin
        if (uo_rdata >= d ||
            (unit_full[CW-1:0] >> uo_rdata) >= in_heap(units, uo_rdata)) begin
          state_d = S_DONE;
        end else begin
          ord_d = uo_rdata; n_d = unit_full[CW-1:0] >> uo_rdata;
          setv_d = 1'b0; k_d = uo_rdata; j_d = '0; jend_d = '0;
          if (uo_rdata != 4'd0) begin
            k_d = uo_rdata - 4'd1;
            j_d = (unit_full[CW-1:0] >> uo_rdata) << 1;
            jend_d = ((unit_full[CW-1:0] >> uo_rdata) + 1'b1) << 1;
          end
          state_d = S_DESC;
        end
      end
      S_BUDDY: begin
        if (used_rd) begin
          st_d = ST_OK; bord_d = ord_q; state_d = S_DONE;
        end else begin
          k_d = ord_q + 4'd1; p_d = n_q; state_d = S_BUDDY_CHK;
        end
      end
      S_BUDDY_CHK: begin
        // clear parent at k, then test its buddy
        if (k_q >= d) begin
          st_d = ST_OK; bord_d = ord_q; state_d = S_DONE;
        end else begin
          p_d = p_q >> 1; rk_d = k_q; rn_d = (p_q >> 1) ^ CW'(1);
          if (k_q == d - 4'd1) k_d = d;
          else k_d = k_q + 4'd1;
          state_d = S_ANC_CHK;
        end
      end
      S_DONE: begin
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    we = 1'b0; waddr = '0; wdata = setv_q;
    raddr = slot(rk_d, rn_d);
    uo_we = 1'b0; uo_waddr = UW'(n_q << ord_q);
    case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q[SW-1:0]; wdata = 1'b0;
      end
      S_SCAN_CHK: begin
        if (!used_rd) begin
          we = 1'b1; waddr = slot(ord_q, n_q); wdata = 1'b1; uo_we = 1'b1;
        end
      end
      S_FREE_ORD: begin
        if (state_d == S_DESC) begin
          we = 1'b1; waddr = slot(uo_rdata, unit_full[CW-1:0] >> uo_rdata); wdata = 1'b0;
        end
      end
      S_DESC: begin
        if (!(k_q == ord_q || k_q == 4'hF) && j_q < in_heap(units, k_q)) begin
          we = 1'b1; waddr = slot(k_q, j_q);
        end
      end
      S_ANC_CHK: begin
        if (setv_q && !used_rd) begin
          we = 1'b1; waddr = slot(rk_q, rn_q); wdata = 1'b1;
        end
      end
      S_BUDDY_CHK: begin
        if (k_q < d && (p_q >> 1) < in_heap(units, k_q)) begin
          we = 1'b1; waddr = slot(k_q, p_q >> 1); wdata = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0; ov_q <= 1'b0; st_q <= '0; setv_q <= 1'b0;
      ord_q <= '0; k_q <= '0; n_q <= '0; p_q <= '0; j_q <= '0; jend_q <= '0;
      rk_q <= '0; rn_q <= '0; baddr_q <= '0; bord_q <= '0;
      size_q <= '0; addr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d; ov_q <= ov_d; st_q <= st_d; setv_q <= setv_d;
      ord_q <= ord_d; k_q <= k_d; n_q <= n_d; p_q <= p_d; j_q <= j_d; jend_q <= jend_d;
      rk_q <= rk_d; rn_q <= rn_d; baddr_q <= baddr_d; bord_q <= bord_d;
      if (state_q == S_IDLE && in_valid_i && !ov_q) begin
        size_q <= req_size_i; addr_q <= free_addr_i;
      end
    end
  end

  assign in_ready_o    = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign block_addr_o  = baddr_q;
  assign block_order_o = bord_q;

  // a result only comes out of a finished command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result without command");
  // no input taken while clearing or busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE && !out_valid_o)
    else $error("ready while busy");
  // a good allocate or free reports an order below MAX_ORDERS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> 32'(block_order_o) < MAX_ORDERS)
    else $error("order out of range");
  // a waiting result beat holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(block_addr_o) && $stable(block_order_o))
    else $error("result changed while waiting");
endmodule
